/* rtl/bsr_pkg.sv */
// Shared types, codes and helpers for the brush stroke rasterizer.
package bsr_pkg;

  localparam int CANVAS_WIDTH_DEF  = 320;
  localparam int CANVAS_HEIGHT_DEF = 240;

  localparam logic [2:0] BRUSH_RADIUS_RESET = 3'd2;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] PHASE_DOWN = 2'd0;
  localparam logic [1:0] PHASE_UP   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STAMP,
    S_CLEAR,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_t;

  // square of a small signed brush offset
  function automatic logic [7:0] sq(input logic signed [3:0] v);
    logic [3:0] m;
    m = v[3] ? 4'(-v) : 4'(v);
    return 8'(m) * 8'(m);
  endfunction

endpackage

/* rtl/bsr_ram.sv */
// Generic single-port synchronous RAM with registered read.
module bsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/brush_stroke_rasterizer.sv */
// Brush stroke rasterizer top level: sequencer, address pipeline and frame store.
//
// Draws pen strokes with a round brush into a CANVAS_WIDTH x CANVAS_HEIGHT RGB565
// frame store held in one single-port RAM. Every pixel access goes through that
// one port, one access per cycle, so item time is set by the number of pixel
// cells visited plus pipeline drain and result handoff: a pen point that stamps
// one disc visits (2r+1)^2 cells (r = brush_radius), a stroke visits
// (steps+1) * (2r+1)^2 cells where steps is the larger of |dx| and |dy| of the
// segment, a clear visits CANVAS_WIDTH*CANVAS_HEIGHT cells, and a pixel read
// visits one. One request is worked on at a time; the next
// request is taken as soon as the previous result sits in the output register.
// The frame store is not initialized at reset; read only pixels that were
// cleared or drawn. brush_radius may be written only while the block is idle.
module brush_stroke_rasterizer #(
  parameter int CANVAS_WIDTH  = bsr_pkg::CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = bsr_pkg::CANVAS_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [1:0]         phase,
  input  logic signed [10:0] x_coord,
  input  logic signed [10:0] y_coord,
  input  logic [15:0]        ink_color,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        pixel_color,
  output logic               pen_down,
  // brush radius register
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata
);

  localparam int XW    = $clog2(CANVAS_WIDTH);
  localparam int YW    = $clog2(CANVAS_HEIGHT);
  localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = ((XW > YW) ? XW : YW) + 3;  // Bresenham deltas and error

  bsr_pkg::state_t state, state_next;

  // configuration and pen state
  logic [2:0]    brush_radius;
  logic [XW-1:0] pen_x;
  logic [YW-1:0] pen_y;
  logic          pen_valid;

  // current request
  logic [15:0]   col;
  logic [15:0]   res_pix;
  logic          res_pen;

  // walk state: segment point (also clear scan and read position)
  logic [XW-1:0]        ax, bx;
  logic [YW-1:0]        ay, by;
  logic signed [DW-1:0] ddx, ddy, acc;
  logic                 stx, sty;
  logic signed [3:0]    dx, dy;

  // access pipeline: s1 coords, s2 address, s3 read return
  logic          s1_we, s1_re, s2_we, s2_re, s3_re;
  logic [XW-1:0] s1_x;
  logic [YW-1:0] s1_y;
  logic [15:0]   s1_data, s2_data;
  logic [AW-1:0] s2_addr;
  logic [15:0]   ram_rdata;

  // ---------------------------------------------------------------- clamping
  logic [XW-1:0] in_x;
  logic [YW-1:0] in_y;

  always_comb begin
    if (x_coord[10]) begin
      in_x = '0;
    end else if ({1'b0, x_coord[9:0]} > 11'(CANVAS_WIDTH - 1)) begin
      in_x = XW'(CANVAS_WIDTH - 1);
    end else begin
      in_x = XW'(x_coord[9:0]);
    end
    if (y_coord[10]) begin
      in_y = '0;
    end else if ({1'b0, y_coord[9:0]} > 11'(CANVAS_HEIGHT - 1)) begin
      in_y = YW'(CANVAS_HEIGHT - 1);
    end else begin
      in_y = YW'(y_coord[9:0]);
    end
  end

  // Segment start: held pen position, or the new point itself when the pen
  // is lifted or coming down (a zero-length segment stamps one disc).
  logic                 stamp_only;
  logic [XW-1:0]        st_x;
  logic [YW-1:0]        st_y;
  logic signed [DW-1:0] sx, sy, ex, ey, new_ddx, new_ddy;

  always_comb begin
    stamp_only = (phase == bsr_pkg::PHASE_DOWN) || !pen_valid;
    st_x    = stamp_only ? in_x : pen_x;
    st_y    = stamp_only ? in_y : pen_y;
    sx      = $signed(DW'(st_x));
    sy      = $signed(DW'(st_y));
    ex      = $signed(DW'(in_x));
    ey      = $signed(DW'(in_y));
    new_ddx = (ex > sx) ? ex - sx : sx - ex;
    new_ddy = (ey > sy) ? sy - ey : ey - sy;
  end

  // ------------------------------------------------------------ disc cell test
  logic signed [3:0]    r_s;
  logic signed [XW+1:0] px;
  logic signed [YW+1:0] py;
  logic                 in_disc, in_bounds, disc_last, seg_end;

  always_comb begin
    r_s       = $signed({1'b0, brush_radius});
    px        = $signed({2'b00, ax}) + $signed({{(XW - 2){dx[3]}}, dx});
    py        = $signed({2'b00, ay}) + $signed({{(YW - 2){dy[3]}}, dy});
    in_disc   = ({1'b0, bsr_pkg::sq(dx)} + {1'b0, bsr_pkg::sq(dy)})
                <= {1'b0, bsr_pkg::sq(r_s)};
    in_bounds = !px[XW+1] && (px < $signed((XW + 2)'(CANVAS_WIDTH)))
             && !py[YW+1] && (py < $signed((YW + 2)'(CANVAS_HEIGHT)));
    disc_last = (dx == r_s) && (dy == r_s);
    seg_end   = (ax == bx) && (ay == by);
  end

  // Bresenham step
  logic signed [DW:0]   twice;
  logic                 step_x, step_y;
  logic signed [DW-1:0] acc_next;

  always_comb begin
    twice    = {acc, 1'b0};
    step_x   = twice >= $signed({ddy[DW-1], ddy});
    step_y   = twice <= $signed({ddx[DW-1], ddx});
    acc_next = acc + (step_x ? ddy : DW'(0)) + (step_y ? ddx : DW'(0));
  end

  logic clear_last, pipe_empty, out_load;

  assign clear_last = (ax == XW'(CANVAS_WIDTH - 1)) && (ay == YW'(CANVAS_HEIGHT - 1));
  assign pipe_empty = !s1_we && !s1_re && !s2_we && !s2_re && !s3_re;

  // ------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      bsr_pkg::S_IDLE: begin
        if (in_valid) begin
          case (kind)
            bsr_pkg::KIND_POINT: state_next = bsr_pkg::S_STAMP;
            bsr_pkg::KIND_CLEAR: state_next = bsr_pkg::S_CLEAR;
            bsr_pkg::KIND_READ:  state_next = bsr_pkg::S_READ;
            default:             state_next = bsr_pkg::S_DRAIN;
          endcase
        end
      end
      bsr_pkg::S_STAMP: if (disc_last && seg_end) state_next = bsr_pkg::S_DRAIN;
      bsr_pkg::S_CLEAR: if (clear_last) state_next = bsr_pkg::S_DRAIN;
      bsr_pkg::S_READ:  state_next = bsr_pkg::S_DRAIN;
      bsr_pkg::S_DRAIN: if (pipe_empty) state_next = bsr_pkg::S_DONE;
      bsr_pkg::S_DONE:  if (!out_valid || out_ready) state_next = bsr_pkg::S_IDLE;
      default:          state_next = bsr_pkg::S_IDLE;
    endcase
  end

  // ----------------------------------------------------------------- outputs
  logic          inj_we, inj_re;
  logic [XW-1:0] inj_x;
  logic [YW-1:0] inj_y;

  always_comb begin
    in_ready = 1'b0;
    inj_we   = 1'b0;
    inj_re   = 1'b0;
    inj_x    = ax;
    inj_y    = ay;
    out_load = 1'b0;
    case (state)
      bsr_pkg::S_IDLE:  in_ready = 1'b1;
      bsr_pkg::S_STAMP: begin
        inj_we = in_disc && in_bounds;
        inj_x  = px[XW-1:0];
        inj_y  = py[YW-1:0];
      end
      bsr_pkg::S_CLEAR: inj_we = 1'b1;
      bsr_pkg::S_READ:  inj_re = 1'b1;
      bsr_pkg::S_DONE:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bsr_pkg::S_IDLE;
      brush_radius <= bsr_pkg::BRUSH_RADIUS_RESET;
      pen_x        <= '0;
      pen_y        <= '0;
      pen_valid    <= 1'b0;
      s1_we        <= 1'b0;
      s1_re        <= 1'b0;
      s2_we        <= 1'b0;
      s2_re        <= 1'b0;
      s3_re        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        brush_radius <= cfg_wdata;
      end
      s1_we <= inj_we;
      s1_re <= inj_re;
      s2_we <= s1_we;
      s2_re <= s1_re;
      s3_re <= s2_re;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        case (kind)
          bsr_pkg::KIND_POINT: begin
            pen_x     <= in_x;
            pen_y     <= in_y;
            pen_valid <= (phase != bsr_pkg::PHASE_UP);
          end
          bsr_pkg::KIND_CLEAR: pen_valid <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    s1_x    <= inj_x;
    s1_y    <= inj_y;
    s1_data <= col;
    s2_addr <= AW'(s1_y) * AW'(CANVAS_WIDTH) + AW'(s1_x);
    s2_data <= s1_data;
    if (s3_re) begin
      res_pix <= ram_rdata;
    end
    if (out_load) begin
      pixel_color <= res_pix;
      pen_down    <= res_pen;
    end
    case (state)
      bsr_pkg::S_IDLE: begin
        col     <= ink_color;
        res_pix <= '0;
        dx      <= -r_s;
        dy      <= -r_s;
        case (kind)
          bsr_pkg::KIND_POINT: begin
            ax      <= st_x;
            ay      <= st_y;
            bx      <= in_x;
            by      <= in_y;
            ddx     <= new_ddx;
            ddy     <= new_ddy;
            acc     <= new_ddx + new_ddy;
            stx     <= sx < ex;
            sty     <= sy < ey;
            res_pen <= (phase != bsr_pkg::PHASE_UP);
          end
          bsr_pkg::KIND_CLEAR: begin
            ax      <= '0;
            ay      <= '0;
            res_pen <= 1'b0;
          end
          bsr_pkg::KIND_READ: begin
            ax      <= in_x;
            ay      <= in_y;
            res_pen <= pen_valid;
          end
          default: res_pen <= pen_valid;
        endcase
      end
      bsr_pkg::S_STAMP: begin
        if (disc_last) begin
          dx <= -r_s;
          dy <= -r_s;
          if (!seg_end) begin
            acc <= acc_next;
            if (step_x) ax <= stx ? ax + XW'(1) : ax - XW'(1);
            if (step_y) ay <= sty ? ay + YW'(1) : ay - YW'(1);
          end
        end else if (dx == r_s) begin
          dx <= -r_s;
          dy <= dy + 4'sd1;
        end else begin
          dx <= dx + 4'sd1;
        end
      end
      bsr_pkg::S_CLEAR: begin
        if (ax == XW'(CANVAS_WIDTH - 1)) begin
          ax <= '0;
          ay <= ay + YW'(1);
        end else begin
          ax <= ax + XW'(1);
        end
      end
      default: ;
    endcase
  end

  bsr_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (s2_we),
    .addr (s2_addr),
    .wdata(s2_data),
    .rdata(ram_rdata)
  );

endmodule

/* rtl/bsr_checker.sv */
// Port-level checker for the brush stroke rasterizer, bound to the top level.
module bsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pixel_color,
  input logic        pen_down
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_color) && $stable(pen_down))
    else $error("result changed while stalled");

  // one request at a time: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // no result appears in the cycle after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result without work");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind brush_stroke_rasterizer bsr_checker u_bsr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pixel_color(pixel_color),
  .pen_down   (pen_down)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for brush_stroke_rasterizer: pen strokes, clears and pixel reads.
`timescale 1ns / 1ps

module tb_top;

  localparam int W = bsr_pkg::CANVAS_WIDTH_DEF;
  localparam int H = bsr_pkg::CANVAS_HEIGHT_DEF;

  // codes the package leaves unnamed
  localparam logic [1:0] KIND_SPARE  = 2'd3;  // draws nothing, but still returns a result
  localparam logic [1:0] PHASE_MOVE  = 2'd1;
  localparam logic [1:0] PHASE_SPARE = 2'd3;  // behaves as move

  // worst sender gap + worst receiver stall + pipeline, per request
  localparam longint SLACK_PER_REQ = 400;

  typedef struct {
    logic [1:0]         kind;
    logic [1:0]         phase;
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic [15:0]        ink;
  } pen_req_t;

  typedef struct {
    bit [15:0] pixel;
    bit        pen;
  } pen_result_t;

  // Mirror of the frame store and pen; predicts one result per request.
  class canvas_mirror;
    bit [15:0]   canvas [W*H];
    int          pen_x = 0;
    int          pen_y = 0;
    bit          pen_held = 1'b0;
    int          radius = int'(bsr_pkg::BRUSH_RADIUS_RESET);
    pen_result_t owed_results [$];
    int          mismatch_count = 0;

    function int clamp(int v, int top);
      if (v < 0) return 0;
      if (v > top - 1) return top - 1;
      return v;
    endfunction

    function void set_radius(int r);
      radius = r;
    endfunction

    // round disc, pixels off the canvas dropped
    function void stamp_disc(int cx, int cy, bit [15:0] ink);
      int dx, dy, px, py;
      for (dy = -radius; dy <= radius; dy++) begin
        for (dx = -radius; dx <= radius; dx++) begin
          px = cx + dx;
          py = cy + dy;
          if (dx * dx + dy * dy <= radius * radius && px >= 0 && px < W &&
              py >= 0 && py < H)
            canvas[py * W + px] = ink;
        end
      end
    endfunction

    // Bresenham walk, disc at every step; returns the number of discs
    function int walk_line(int ax, int ay, int bx, int by, bit [15:0] ink);
      int adx, ady, sx, sy, err, e2, discs;
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? ay - by : by - ay;
      sx = (ax < bx) ? 1 : -1;
      sy = (ay < by) ? 1 : -1;
      err = adx + ady;
      discs = 0;
      while (1) begin
        stamp_disc(ax, ay, ink);
        discs++;
        if (ax == bx && ay == by) break;
        e2 = 2 * err;
        if (e2 >= ady) begin
          err += ady;
          ax += sx;
        end
        if (e2 <= adx) begin
          err += adx;
          ay += sy;
        end
      end
      return discs;
    endfunction

    // apply an accepted request; returns its cost in cycles for the watchdog
    function longint note_request(pen_req_t rq);
      int          x, y, discs;
      longint      cells;
      pen_result_t res;
      x = clamp(int'(rq.x), W);
      y = clamp(int'(rq.y), H);
      res.pixel = '0;
      cells = 8;
      discs = 0;
      case (rq.kind)
        bsr_pkg::KIND_POINT: begin
          if (rq.phase == bsr_pkg::PHASE_DOWN || !pen_held) begin
            stamp_disc(x, y, rq.ink);
            discs = 1;
          end else begin
            discs = walk_line(pen_x, pen_y, x, y, rq.ink);
          end
          pen_x = x;
          pen_y = y;
          pen_held = (rq.phase != bsr_pkg::PHASE_UP);
        end
        bsr_pkg::KIND_CLEAR: begin
          foreach (canvas[i]) canvas[i] = rq.ink;
          pen_held = 1'b0;
          cells = W * H;
        end
        bsr_pkg::KIND_READ: begin
          res.pixel = canvas[y * W + x];
        end
        default: ;
      endcase
      res.pen = pen_held;
      owed_results.push_back(res);
      return cells + longint'(discs) * (2 * radius + 1) * (2 * radius + 1);
    endfunction

    task report(string msg);
      mismatch_count++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [15:0] pixel, logic pen);
      pen_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unrequested result: pixel %h pen_down %b", pixel, pen));
        return;
      end
      want = owed_results.pop_front();
      if (pixel !== want.pixel)
        report($sformatf("pixel_color got %h want %h", pixel, want.pixel));
      if (pen !== want.pen)
        report($sformatf("pen_down got %b want %b", pen, want.pen));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         kind;
  logic [1:0]         phase;
  logic signed [10:0] x_coord;
  logic signed [10:0] y_coord;
  logic [15:0]        ink_color;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        pixel_color;
  logic               pen_down;
  logic               cfg_we;
  logic [2:0]         cfg_wdata;

  canvas_mirror mirror;
  longint       work_budget = 0;  // cycles the accepted work may take
  longint       cycle_count = 0;
  int           tx_burst = 0;     // requests left in a back-to-back run
  int           near_x = 160;     // where random strokes wander around
  int           near_y = 120;

  brush_stroke_rasterizer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .phase       (phase),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .ink_color   (ink_color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_color (pixel_color),
    .pen_down    (pen_down),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: the limit grows with the work accepted, so long strokes and
  // clears never trip it, but a hung block does.
  initial begin : watchdog
    while (cycle_count <= 4 * work_budget + 200000) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one request and hold it until taken. Valid is left high when no
  // gap follows, so the caller must present the next request (or drop
  // valid) in the same time step.
  task automatic push_req(input logic [1:0] k, input logic [1:0] ph, input int xv,
                          input int yv, input logic [15:0] ink);
    pen_req_t rq;
    int       gap;
    int       roll;
    rq.kind  = k;
    rq.phase = ph;
    rq.x     = 11'(xv);
    rq.y     = 11'(yv);
    rq.ink   = ink;
    in_valid  <= 1'b1;
    kind      <= rq.kind;
    phase     <= rq.phase;
    x_coord   <= rq.x;
    y_coord   <= rq.y;
    ink_color <= rq.ink;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    work_budget += mirror.note_request(rq) + SLACK_PER_REQ;
    // gap before the next request: mostly none or short, a few long
    if (tx_burst > 0) begin
      tx_burst--;
      gap = 0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        tx_burst = $urandom_range(20, 60);
        gap = 0;
      end else if (roll < 45) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 96) gap = $urandom_range(4, 20);
      else gap = $urandom_range(40, 200);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (mirror.owed_results.size() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_radius(input int r);
    cfg_we    <= 1'b1;
    cfg_wdata <= 3'(r);
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_radius(r);
  endtask

  // Random traffic: mostly well-formed strokes (down, moves, up) that wander
  // near the pen, with reads mixed in, rare clears, far jumps that clamp,
  // and a bit of noise (strokes that start without a down, spare kinds).
  task automatic scribble(input int count);
    int         sent, roll, pick, tx, ty, left;
    logic [1:0] ph;
    sent = 0;
    left = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 199);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // full 11-bit range, mostly clamped
        tx = int'($urandom_range(0, 2047)) - 1024;
        ty = int'($urandom_range(0, 2047)) - 1024;
      end else if (pick < 10) begin
        tx = $urandom_range(0, W - 1);
        ty = $urandom_range(0, H - 1);
      end else begin
        tx = near_x + int'($urandom_range(0, 24)) - 12;
        ty = near_y + int'($urandom_range(0, 24)) - 12;
      end
      if (roll == 0) begin
        push_req(bsr_pkg::KIND_CLEAR, 2'($urandom_range(0, 3)), tx, ty, 16'($urandom));
        left = 0;
        sent++;
      end else if (roll < 8) begin
        // draws nothing but returns a result, not counted
        push_req(KIND_SPARE, 2'($urandom_range(0, 3)), tx, ty, 16'($urandom));
      end else if (roll < 50) begin
        push_req(bsr_pkg::KIND_READ, 2'($urandom_range(0, 3)), tx, ty, 16'($urandom));
        sent++;
      end else begin
        if (left == 0) begin
          // new stroke; now and then a broken start with no down
          ph = (roll < 58) ? 2'($urandom_range(0, 3)) : bsr_pkg::PHASE_DOWN;
          left = $urandom_range(1, 8);
        end else if (left == 1) begin
          ph = bsr_pkg::PHASE_UP;
          left = 0;
        end else begin
          ph = ($urandom_range(0, 9) == 0) ? PHASE_SPARE : PHASE_MOVE;
          left--;
        end
        push_req(bsr_pkg::KIND_POINT, ph, tx, ty, 16'($urandom));
        near_x = mirror.clamp(tx, W);
        near_y = mirror.clamp(ty, H);
        sent++;
      end
    end
  endtask

  // Result side: random stalls, back-to-back stretches, and one long
  // hold-off so the block fills up and stalls its request input.
  initial begin : result_sink
    int stall, eager, taken, roll;
    bit held_off;
    stall = 0;
    eager = 0;
    taken = 0;
    held_off = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        mirror.check_result(pixel_color, pen_down);
        taken++;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (!held_off && taken == 150) begin
        held_off = 1'b1;
        stall = 800;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (eager > 0) begin
        eager--;
        out_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          eager = $urandom_range(50, 300);
          out_ready <= 1'b1;
        end else if (roll < 70) begin
          out_ready <= 1'b1;
        end else if (roll < 95) begin
          stall = $urandom_range(0, 3);
          out_ready <= 1'b0;
        end else begin
          stall = $urandom_range(10, 120);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    mirror = new;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    kind      <= bsr_pkg::KIND_POINT;
    phase     <= bsr_pkg::PHASE_DOWN;
    x_coord   <= '0;
    y_coord   <= '0;
    ink_color <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset radius. The clear comes first so that no
    // pixel is ever read before it holds a value.
    push_req(bsr_pkg::KIND_CLEAR, bsr_pkg::PHASE_DOWN, 0, 0, 16'hFFFF);
    push_req(bsr_pkg::KIND_READ, bsr_pkg::PHASE_DOWN, 0, 0, 16'h0000);
    // corner disc, mostly off canvas, both coordinates clamped from the minimum
    push_req(bsr_pkg::KIND_POINT, bsr_pkg::PHASE_DOWN, -1024, -1024, 16'h0000);
    push_req(bsr_pkg::KIND_READ, PHASE_MOVE, 0, 0, 16'hFFFF);
    // full top row, then full right column ending in a lift
    push_req(bsr_pkg::KIND_POINT, PHASE_MOVE, 1023, -1024, 16'hF800);
    push_req(bsr_pkg::KIND_READ, bsr_pkg::PHASE_UP, 1023, -5, 16'h0000);
    push_req(bsr_pkg::KIND_POINT, bsr_pkg::PHASE_UP, 1023, 1023, 16'h07E0);
    push_req(bsr_pkg::KIND_READ, bsr_pkg::PHASE_DOWN, 1023, 1023, 16'h0000);
    // move with the pen lifted stamps a single disc
    push_req(bsr_pkg::KIND_POINT, PHASE_MOVE, 100, 100, 16'h001F);
    // spare phase draws like a move
    push_req(bsr_pkg::KIND_POINT, PHASE_SPARE, 103, 98, 16'h1234);
    push_req(KIND_SPARE, bsr_pkg::PHASE_UP, 200, 200, 16'hBEEF);
    // down with the pen held stamps without a line
    push_req(bsr_pkg::KIND_POINT, bsr_pkg::PHASE_DOWN, 50, 50, 16'hABCD);
    push_req(bsr_pkg::KIND_READ, bsr_pkg::PHASE_DOWN, 50, 52, 16'h0000);
    push_req(bsr_pkg::KIND_READ, bsr_pkg::PHASE_DOWN, 52, 52, 16'h0000);
    push_req(bsr_pkg::KIND_READ, bsr_pkg::PHASE_DOWN, 101, 99, 16'h0000);
    push_req(bsr_pkg::KIND_READ, PHASE_SPARE, -1, -1, 16'h0000);
    push_req(bsr_pkg::KIND_READ, PHASE_MOVE, 319, 239, 16'h0000);
    // clear lifts the pen
    push_req(bsr_pkg::KIND_CLEAR, PHASE_SPARE, -1024, 1023, 16'h0000);
    push_req(bsr_pkg::KIND_POINT, bsr_pkg::PHASE_UP, 160, 120, 16'h5555);
    push_req(bsr_pkg::KIND_READ, bsr_pkg::PHASE_DOWN, 160, 120, 16'h0000);
    push_req(KIND_SPARE, PHASE_SPARE, -1024, -1024, 16'hFFFF);
    push_req(bsr_pkg::KIND_POINT, PHASE_MOVE, 319, 239, 16'h7BEF);
    push_req(bsr_pkg::KIND_POINT, PHASE_MOVE, 0, 0, 16'h8410);
    push_req(bsr_pkg::KIND_READ, bsr_pkg::PHASE_DOWN, 160, 120, 16'h0000);

    // Random part over several radii, extremes included. Each radius change
    // waits for the block to go idle, which also pauses the sender until
    // every result is back.
    drain_results();
    write_radius(0);
    scribble(60);
    drain_results();
    write_radius(7);
    scribble(50);
    drain_results();
    write_radius(1);
    scribble(60);
    drain_results();
    write_radius(3);
    scribble(60);
    drain_results();
    write_radius($urandom_range(0, 7));
    scribble(70);

    drain_results();
    repeat (40) @(posedge clk);
    if (mirror.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
